FILE: hdl/ecsm_pkg.sv
`default_nettype none
package ecsm_pkg;

    // configuration register indexes
    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_CURVE_A = 1'b1;

    localparam int unsigned MODULUS_RESET = 167;
    localparam int unsigned CURVE_A_RESET = 11;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } dp_op_t;

    // datapath register file names; ZERO, ONE, M and A are read-only sources
    typedef enum logic [4:0] {
        R_ZERO,
        R_ONE,
        R_M,
        R_A,
        R_AR,
        R_BX,
        R_BY,
        R_PX,
        R_PY,
        R_QX,
        R_QY,
        R_NUM,
        R_DEN,
        R_S,
        R_T0,
        R_T1,
        R_R0,
        R_R1,
        R_QT,
        R_TMP,
        R_RX
    } dp_reg_t;

    typedef struct packed {
        logic    go;
        logic    load_in;
        dp_op_t  op;
        dp_reg_t dst;
        dp_reg_t src_a;
        dp_reg_t src_b;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic eq_x;
        logic eq_y;
        logic py_zero;
        logic r1_zero;
        logic r0_one;
        logic m_small;
    } dp_status_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_LD_RX,
        ST_LD_RY,
        ST_LD_RA,
        ST_BIT_TOP,
        ST_POST,
        ST_CPB_X,
        ST_CPB_Y,
        ST_CPQ_X,
        ST_CPQ_Y,
        ST_CHECK,
        ST_D_SQ,
        ST_D_T2,
        ST_D_T3,
        ST_D_NA,
        ST_D_DEN,
        ST_C_NUM,
        ST_C_DEN,
        ST_INV_I0,
        ST_INV_I1,
        ST_INV_I2,
        ST_INV_I3,
        ST_INV_TEST,
        ST_INV_DIV,
        ST_INV_MUL,
        ST_INV_SUB,
        ST_INV_SH0,
        ST_INV_SH1,
        ST_INV_SH2,
        ST_INV_SH3,
        ST_S_MUL,
        ST_P_SS,
        ST_P_RX1,
        ST_P_RX2,
        ST_P_D,
        ST_P_E,
        ST_P_RY,
        ST_P_WX,
        ST_P_WY,
        ST_OUT
    } ctrl_state_t;

endpackage
`default_nettype wire

FILE: hdl/ecsm_modmul.sv
`default_nettype none
module ecsm_modmul #(
    parameter int W = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] u,
    input  wire logic [W-1:0] v,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      p
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  u_reg;
    logic [W-1:0]  v_reg;
    logic [W-1:0]  acc_reg;
    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W:0]    sum_red;

    // acc = (2*acc + bit*v) mod m, msb of u first; v < m keeps each sum below 2m
    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        sum     = dbl_red + (u_reg[W-1] ? {1'b0, v_reg} : '0);
        sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            u_reg   <= u;
            v_reg   <= v;
            acc_reg <= '0;
        end else if (busy_reg) begin
            u_reg   <= {u_reg[W-2:0], 1'b0};
            acc_reg <= sum_red[W-1:0];
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

FILE: hdl/ecsm_div.sv
`default_nettype none
module ecsm_div #(
    parameter int W = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] n,
    input  wire logic [W-1:0] d,
    output logic              done,
    output logic [W-1:0]      q,
    output logic [W-1:0]      r
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  d_reg;
    logic [W-1:0]  rem_reg;
    logic [W:0]    trial;
    logic          fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, q_reg[W-1]};
        fits  = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[W-2:0], fits};
            rem_reg <= fits ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign r    = rem_reg;
endmodule
`default_nettype wire

FILE: hdl/ecsm_dp.sv
`default_nettype none
module ecsm_dp #(
    parameter int W = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_addr,
    input  wire logic [W-1:0]         cfg_wdata,
    input  wire logic [W-1:0]         in_x,
    input  wire logic [W-1:0]         in_y,
    input  wire ecsm_pkg::dp_cmd_t    cmd,
    output ecsm_pkg::dp_status_t      st,
    output logic [W-1:0]              acc_x,
    output logic [W-1:0]              acc_y
);
    import ecsm_pkg::*;

    logic [W-1:0] m_reg, a_reg, ar_reg, bx_reg, by_reg, px_reg, py_reg, qx_reg, qy_reg;
    logic [W-1:0] num_reg, den_reg, s_reg, t0_reg, t1_reg, r0_reg, r1_reg, qt_reg;
    logic [W-1:0] tmp_reg, rx_reg;
    dp_reg_t      dst_reg;
    logic         done_reg;

    logic [W-1:0] opa, opb, alu;
    logic [W:0]   sum;
    logic         simple_go;
    logic         mul_start, mul_done, div_start, div_done;
    logic [W-1:0] mul_p, div_q, div_r;
    logic         wr_en;
    dp_reg_t      wr_dst;
    logic [W-1:0] wr_val;

    function automatic logic [W-1:0] pick(input dp_reg_t sel,
            input logic [W-1:0] m, input logic [W-1:0] a, input logic [W-1:0] ar,
            input logic [W-1:0] bx, input logic [W-1:0] by, input logic [W-1:0] px,
            input logic [W-1:0] py, input logic [W-1:0] qx, input logic [W-1:0] qy,
            input logic [W-1:0] num, input logic [W-1:0] den, input logic [W-1:0] s,
            input logic [W-1:0] t0, input logic [W-1:0] t1, input logic [W-1:0] r0,
            input logic [W-1:0] r1, input logic [W-1:0] qt, input logic [W-1:0] tmp,
            input logic [W-1:0] rx);
        logic [W-1:0] val;
        case (sel)
            R_ZERO:  val = '0;
            R_ONE:   val = W'(1);
            R_M:     val = m;
            R_A:     val = a;
            R_AR:    val = ar;
            R_BX:    val = bx;
            R_BY:    val = by;
            R_PX:    val = px;
            R_PY:    val = py;
            R_QX:    val = qx;
            R_QY:    val = qy;
            R_NUM:   val = num;
            R_DEN:   val = den;
            R_S:     val = s;
            R_T0:    val = t0;
            R_T1:    val = t1;
            R_R0:    val = r0;
            R_R1:    val = r1;
            R_QT:    val = qt;
            R_TMP:   val = tmp;
            R_RX:    val = rx;
            default: val = '0;
        endcase
        return val;
    endfunction

    always_comb begin
        opa = pick(cmd.src_a, m_reg, a_reg, ar_reg, bx_reg, by_reg, px_reg, py_reg,
                   qx_reg, qy_reg, num_reg, den_reg, s_reg, t0_reg, t1_reg, r0_reg,
                   r1_reg, qt_reg, tmp_reg, rx_reg);
        opb = pick(cmd.src_b, m_reg, a_reg, ar_reg, bx_reg, by_reg, px_reg, py_reg,
                   qx_reg, qy_reg, num_reg, den_reg, s_reg, t0_reg, t1_reg, r0_reg,
                   r1_reg, qt_reg, tmp_reg, rx_reg);
    end

    // modular add and subtract; both operands are already below m
    always_comb begin
        sum = '0;
        alu = opa;
        case (cmd.op)
            OP_ADD: begin
                sum = {1'b0, opa} + {1'b0, opb};
                alu = (sum >= {1'b0, m_reg}) ? W'(sum - {1'b0, m_reg}) : sum[W-1:0];
            end
            OP_SUB: begin
                alu = (opa >= opb) ? opa - opb : W'({1'b0, opa} + {1'b0, m_reg} - {1'b0, opb});
            end
            default: alu = opa;
        endcase
    end

    assign simple_go = cmd.go && (cmd.op == OP_MOV || cmd.op == OP_ADD || cmd.op == OP_SUB);
    assign mul_start = cmd.go && (cmd.op == OP_MUL);
    assign div_start = cmd.go && (cmd.op == OP_DIV);

    ecsm_modmul #(.W(W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .u       (opa),
        .v       (opb),
        .m       (m_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    ecsm_div #(.W(W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .n       (opa),
        .d       (opb),
        .done    (div_done),
        .q       (div_q),
        .r       (div_r)
    );

    always_comb begin
        wr_en  = 1'b0;
        wr_dst = cmd.dst;
        wr_val = alu;
        if (simple_go) begin
            wr_en = 1'b1;
        end else if (mul_done) begin
            wr_en  = 1'b1;
            wr_dst = dst_reg;
            wr_val = mul_p;
        end else if (div_done) begin
            wr_en  = 1'b1;
            wr_dst = dst_reg;
            wr_val = div_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_reg    <= W'(MODULUS_RESET);
            a_reg    <= W'(CURVE_A_RESET);
            done_reg <= 1'b0;
        end else begin
            done_reg <= simple_go;
            if (cfg_wr_en && cfg_addr == CFG_MODULUS) begin
                m_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_addr == CFG_CURVE_A) begin
                a_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            dst_reg <= cmd.dst;
        end
        if (cmd.load_in) begin
            bx_reg <= in_x;
            by_reg <= in_y;
        end
        if (wr_en) begin
            case (wr_dst)
                R_AR:    ar_reg  <= wr_val;
                R_BX:    bx_reg  <= wr_val;
                R_BY:    by_reg  <= wr_val;
                R_PX:    px_reg  <= wr_val;
                R_PY:    py_reg  <= wr_val;
                R_QX:    qx_reg  <= wr_val;
                R_QY:    qy_reg  <= wr_val;
                R_NUM:   num_reg <= wr_val;
                R_DEN:   den_reg <= wr_val;
                R_S:     s_reg   <= wr_val;
                R_T0:    t0_reg  <= wr_val;
                R_T1:    t1_reg  <= wr_val;
                R_R0:    r0_reg  <= wr_val;
                R_R1:    r1_reg  <= wr_val;
                R_QT:    qt_reg  <= wr_val;
                R_TMP:   tmp_reg <= wr_val;
                R_RX:    rx_reg  <= wr_val;
                default: ;
            endcase
        end
        // remainder of a division always lands in RX
        if (div_done) begin
            rx_reg <= div_r;
        end
    end

    always_comb begin
        st.done    = done_reg || mul_done || div_done;
        st.eq_x    = (px_reg == qx_reg);
        st.eq_y    = (py_reg == qy_reg);
        st.py_zero = (py_reg == '0);
        st.r1_zero = (r1_reg == '0);
        st.r0_one  = (r0_reg == W'(1));
        st.m_small = (m_reg < W'(2));
    end

    assign acc_x = px_reg;
    assign acc_y = py_reg;
endmodule
`default_nettype wire

FILE: hdl/ecsm_ctrl.sv
`default_nettype none
module ecsm_ctrl #(
    parameter int SB = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [SB-1:0]        in_scalar,
    input  wire logic                 out_free,
    output logic                      out_load,
    output logic                      out_inf,
    output ecsm_pkg::dp_cmd_t         cmd,
    input  wire ecsm_pkg::dp_status_t st
);
    import ecsm_pkg::*;

    localparam int IW = $clog2(SB);

    ctrl_state_t   state_reg, state_next, follow;
    logic [SB-1:0] k_reg, k_next;
    logic [IW-1:0] bit_reg, bit_next;
    logic          inf_reg, inf_next;
    logic          phase_reg, phase_next;
    logic          issued_reg, issued_next;
    dp_op_t        op;
    dp_reg_t       dst, sa, sb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            inf_reg    <= 1'b1;
            phase_reg  <= 1'b0;
            bit_reg    <= '0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            inf_reg    <= inf_next;
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            k_reg      <= k_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        k_next      = k_reg;
        bit_next    = bit_reg;
        inf_next    = inf_reg;
        phase_next  = phase_reg;
        follow      = state_reg;
        op          = OP_NONE;
        dst         = R_TMP;
        sa          = R_ZERO;
        sb          = R_ZERO;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        cmd.load_in = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    k_next      = in_scalar;
                    bit_next    = IW'(SB - 1);
                    inf_next    = 1'b1;
                    state_next  = st.m_small ? ST_OUT : ST_LD_RX;
                end
            end
            // reduce the base point and curve a modulo m
            ST_LD_RX: begin op = OP_MUL; dst = R_BX; sa = R_BX; sb = R_ONE; follow = ST_LD_RY; end
            ST_LD_RY: begin op = OP_MUL; dst = R_BY; sa = R_BY; sb = R_ONE; follow = ST_LD_RA; end
            ST_LD_RA: begin op = OP_MUL; dst = R_AR; sa = R_A;  sb = R_ONE; follow = ST_BIT_TOP; end
            ST_BIT_TOP: begin
                phase_next = 1'b0;
                state_next = inf_reg ? ST_POST : ST_CPQ_X;
            end
            ST_POST: begin
                if (!phase_reg && k_reg[bit_reg]) begin
                    phase_next = 1'b1;
                    state_next = inf_reg ? ST_CPB_X : ST_CPQ_X;
                end else if (bit_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_BIT_TOP;
                end
            end
            ST_CPB_X: begin op = OP_MOV; dst = R_PX; sa = R_BX; follow = ST_CPB_Y; end
            ST_CPB_Y: begin
                op = OP_MOV; dst = R_PY; sa = R_BY; follow = ST_POST;
                inf_next = 1'b0;
            end
            ST_CPQ_X: begin
                op = OP_MOV; dst = R_QX; sa = phase_reg ? R_BX : R_PX; follow = ST_CPQ_Y;
            end
            ST_CPQ_Y: begin
                op = OP_MOV; dst = R_QY; sa = phase_reg ? R_BY : R_PY; follow = ST_CHECK;
            end
            ST_CHECK: begin
                if (st.eq_x) begin
                    if (!st.eq_y || st.py_zero) begin
                        inf_next   = 1'b1;
                        state_next = ST_POST;
                    end else begin
                        state_next = ST_D_SQ;
                    end
                end else begin
                    state_next = ST_C_NUM;
                end
            end
            // tangent slope: (3x^2 + a) / 2y
            ST_D_SQ:  begin op = OP_MUL; dst = R_TMP; sa = R_PX;  sb = R_PX;  follow = ST_D_T2; end
            ST_D_T2:  begin op = OP_ADD; dst = R_NUM; sa = R_TMP; sb = R_TMP; follow = ST_D_T3; end
            ST_D_T3:  begin op = OP_ADD; dst = R_NUM; sa = R_NUM; sb = R_TMP; follow = ST_D_NA; end
            ST_D_NA:  begin op = OP_ADD; dst = R_NUM; sa = R_NUM; sb = R_AR;  follow = ST_D_DEN; end
            ST_D_DEN: begin op = OP_ADD; dst = R_DEN; sa = R_PY;  sb = R_PY;  follow = ST_INV_I0; end
            // chord slope: (qy - py) / (qx - px)
            ST_C_NUM: begin op = OP_SUB; dst = R_NUM; sa = R_QY;  sb = R_PY;  follow = ST_C_DEN; end
            ST_C_DEN: begin op = OP_SUB; dst = R_DEN; sa = R_QX;  sb = R_PX;  follow = ST_INV_I0; end
            // extended Euclid, with t kept reduced modulo m
            ST_INV_I0: begin op = OP_MOV; dst = R_R0; sa = R_M;    follow = ST_INV_I1; end
            ST_INV_I1: begin op = OP_MOV; dst = R_R1; sa = R_DEN;  follow = ST_INV_I2; end
            ST_INV_I2: begin op = OP_MOV; dst = R_T0; sa = R_ZERO; follow = ST_INV_I3; end
            ST_INV_I3: begin op = OP_MOV; dst = R_T1; sa = R_ONE;  follow = ST_INV_TEST; end
            ST_INV_TEST: begin
                state_next = st.r1_zero ? ST_S_MUL : ST_INV_DIV;
            end
            ST_INV_DIV: begin op = OP_DIV; dst = R_QT;  sa = R_R0; sb = R_R1;  follow = ST_INV_MUL; end
            ST_INV_MUL: begin op = OP_MUL; dst = R_TMP; sa = R_QT; sb = R_T1;  follow = ST_INV_SUB; end
            ST_INV_SUB: begin op = OP_SUB; dst = R_TMP; sa = R_T0; sb = R_TMP; follow = ST_INV_SH0; end
            ST_INV_SH0: begin op = OP_MOV; dst = R_R0;  sa = R_R1;  follow = ST_INV_SH1; end
            ST_INV_SH1: begin op = OP_MOV; dst = R_R1;  sa = R_RX;  follow = ST_INV_SH2; end
            ST_INV_SH2: begin op = OP_MOV; dst = R_T0;  sa = R_T1;  follow = ST_INV_SH3; end
            ST_INV_SH3: begin op = OP_MOV; dst = R_T1;  sa = R_TMP; follow = ST_INV_TEST; end
            // no inverse when the gcd is not one: slope drops to zero
            ST_S_MUL: begin
                op = OP_MUL; dst = R_S; sa = R_NUM; sb = st.r0_one ? R_T0 : R_ZERO;
                follow = ST_P_SS;
            end
            ST_P_SS:  begin op = OP_MUL; dst = R_TMP; sa = R_S;   sb = R_S;   follow = ST_P_RX1; end
            ST_P_RX1: begin op = OP_SUB; dst = R_RX;  sa = R_TMP; sb = R_PX;  follow = ST_P_RX2; end
            ST_P_RX2: begin op = OP_SUB; dst = R_RX;  sa = R_RX;  sb = R_QX;  follow = ST_P_D; end
            ST_P_D:   begin op = OP_SUB; dst = R_TMP; sa = R_PX;  sb = R_RX;  follow = ST_P_E; end
            ST_P_E:   begin op = OP_MUL; dst = R_TMP; sa = R_S;   sb = R_TMP; follow = ST_P_RY; end
            ST_P_RY:  begin op = OP_SUB; dst = R_TMP; sa = R_TMP; sb = R_PY;  follow = ST_P_WX; end
            ST_P_WX:  begin op = OP_MOV; dst = R_PX;  sa = R_RX;  follow = ST_P_WY; end
            ST_P_WY: begin
                op = OP_MOV; dst = R_PY; sa = R_TMP; follow = ST_POST;
                inf_next = 1'b0;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // issue once, then wait for the datapath to report completion
        cmd.go = 1'b0;
        if (op != OP_NONE) begin
            if (!issued_reg) begin
                cmd.go      = 1'b1;
                issued_next = 1'b1;
            end else if (st.done) begin
                issued_next = 1'b0;
                state_next  = follow;
            end
        end
        cmd.op    = op;
        cmd.dst   = dst;
        cmd.src_a = sa;
        cmd.src_b = sb;
    end

    assign out_inf = inf_reg;
endmodule
`default_nettype wire

FILE: hdl/ec_point_scalar_multiply_top.sv
// Elliptic curve scalar multiplication, affine coordinates over GF(modulus).
// Input channel s_*: one transaction carries base_x, base_y and scalar k.
// Output channel m_*: one transaction per input with k times the base point;
// m_tuser flags the point at infinity, and then both coordinates are zero.
// The configuration port writes modulus (index 0) and curve a (index 1);
// write only while no transaction is in flight.
// Schedule: the scalar is scanned msb first, one doubling and, for a set bit,
// one addition. Each point operation runs on a shared datapath: a bit-serial
// modular multiplier and a restoring divider, plus combinational add, subtract
// and move. The modular inverse, an extended Euclid loop, dominates; an item
// takes up to SCALAR_BITS*2 point operations. One item is worked at a time.
// A finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the block stops at the end of the
// following item until the register drains.
// Reset (aresetn low, synchronous) drops any work and pending result and
// restores modulus 167 and curve a 11.
`default_nettype none
module ec_point_scalar_multiply_top #(
    parameter int FIELD_BITS  = 16,
    parameter int SCALAR_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [FIELD_BITS-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // base_x, base_y, scalar (lowest bits first), zero padded
    input  wire logic [((2*FIELD_BITS+SCALAR_BITS+7)/8)*8-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // result_x, result_y (lowest bits first), zero padded
    output logic [((2*FIELD_BITS+7)/8)*8-1:0] m_tdata,
    // at_infinity
    output logic [0:0]                 m_tuser
);
    import ecsm_pkg::*;

    localparam int OUT_TW = ((2*FIELD_BITS+7)/8)*8;

    dp_cmd_t               cmd;
    dp_status_t            st;
    logic                  out_free, out_load, out_inf;
    logic [FIELD_BITS-1:0] acc_x, acc_y;
    logic                  m_tvalid_reg;
    logic [FIELD_BITS-1:0] res_x_reg, res_y_reg;
    logic                  res_inf_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    ecsm_ctrl #(.SB(SCALAR_BITS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_scalar (s_tdata[2*FIELD_BITS +: SCALAR_BITS]),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_inf   (out_inf),
        .cmd       (cmd),
        .st        (st)
    );

    ecsm_dp #(.W(FIELD_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_x      (s_tdata[0 +: FIELD_BITS]),
        .in_y      (s_tdata[FIELD_BITS +: FIELD_BITS]),
        .cmd       (cmd),
        .st        (st),
        .acc_x     (acc_x),
        .acc_y     (acc_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_x_reg   <= out_inf ? '0 : acc_x;
            res_y_reg   <= out_inf ? '0 : acc_y;
            res_inf_reg <= out_inf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'({res_y_reg, res_x_reg});
    assign m_tuser  = res_inf_reg;

    a_inf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("infinity result with nonzero coordinates");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over a pending transaction");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.go |-> !s_tready)
        else $error("input ready while datapath works");
endmodule
`default_nettype wire

FILE: sim/ec_point_scalar_multiply_top_tb.sv
`default_nettype none
module ec_point_scalar_multiply_top_tb;
    import ecsm_pkg::*;

    localparam int FB = 16;
    localparam int SB = 16;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [SB-1:0] scalar;
        logic [FB-1:0] by;
        logic [FB-1:0] bx;
    } base_item_t;

    typedef struct packed {
        logic          inf;
        logic [FB-1:0] ry;
        logic [FB-1:0] rx;
    } mult_res_t;

    typedef struct {
        longint x;
        longint y;
        bit     inf;
    } ec_point_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic                           cfg_addr = CFG_MODULUS;
    logic [FB-1:0]                  cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;
    logic [0:0]                     m_tuser;

    ec_point_scalar_multiply_top #(.FIELD_BITS(FB), .SCALAR_BITS(SB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    base_item_t pending_items[$];
    mult_res_t  expected_points[$];
    longint     field_mod = MODULUS_RESET;
    longint     field_a = CURVE_A_RESET;
    int         mismatches = 0;
    bit         hold_input = 1'b0;
    bit         no_idle = 1'b0;
    logic       in_taken = 1'b0;
    logic       out_taken = 1'b0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         idle_cycles = 0;

    function automatic longint mod_inverse(longint v, longint m);
        longint r0, r1, t0, t1, q, rt, tt;
        r0 = m; r1 = v % m; t0 = 0; t1 = 1;
        if (r1 == 0) return 0;
        while (r1 != 0) begin
            q = r0 / r1;
            rt = r0 - q * r1; tt = t0 - q * t1;
            r0 = r1; r1 = rt; t0 = t1; t1 = tt;
        end
        if (r0 != 1) return 0;
        if (t0 < 0) t0 += m;
        return t0 % m;
    endfunction

    function automatic ec_point_t point_sum(ec_point_t p, ec_point_t q, longint m, longint a);
        ec_point_t r;
        longint num, den, s;
        if (p.inf) return q;
        if (q.inf) return p;
        r.x = 0; r.y = 0; r.inf = 1'b1;
        if (p.x == q.x) begin
            if (p.y != q.y || p.y == 0) return r;
            num = ((3 * ((p.x * p.x) % m)) % m + a) % m;
            den = (2 * p.y) % m;
        end else begin
            num = (q.y + m - p.y) % m;
            den = (q.x + m - p.x) % m;
        end
        s = (num * mod_inverse(den, m)) % m;
        r.x = (((s * s) % m + m - p.x) % m + m - q.x) % m;
        r.y = ((s * ((p.x + m - r.x) % m)) % m + m - p.y) % m;
        r.inf = 1'b0;
        return r;
    endfunction

    function automatic mult_res_t scalar_multiple(base_item_t it);
        mult_res_t res;
        ec_point_t base, acc;
        longint m, a;
        res = '{inf: 1'b1, ry: '0, rx: '0};
        m = field_mod;
        if (m < 2) return res;
        a = field_a % m;
        base.x = it.bx % m; base.y = it.by % m; base.inf = 1'b0;
        acc.x = 0; acc.y = 0; acc.inf = 1'b1;
        for (int i = SB - 1; i >= 0; i--) begin
            acc = point_sum(acc, acc, m, a);
            if (it.scalar[i]) acc = point_sum(acc, base, m, a);
        end
        if (!acc.inf) res = '{inf: 1'b0, ry: acc.y[FB-1:0], rx: acc.x[FB-1:0]};
        return res;
    endfunction

    function automatic int idle_length();
        if (no_idle) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    // accept transactions and check results at the rising edge
    always @(posedge aclk) begin
        mult_res_t want, got;
        in_taken <= aresetn && s_tvalid && s_tready;
        out_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_points.push_back(scalar_multiple(pending_items[0]));
                void'(pending_items.pop_front());
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata};
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result x=%0d y=%0d inf=%0d",
                                 got.rx, got.ry, got.inf);
                end else begin
                    want = expected_points.pop_front();
                    if (got.rx !== want.rx || got.ry !== want.ry || got.inf !== want.inf) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: exp x=%0d y=%0d inf=%0d got x=%0d y=%0d inf=%0d",
                                     want.rx, want.ry, want.inf, got.rx, got.ry, got.inf);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (!s_tvalid && expected_points.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // drive the input channel at the falling edge
    always @(negedge aclk) begin
        logic       v;
        base_item_t d;
        int         g;
        v = s_tvalid; d = s_tdata; g = in_gap;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (in_taken) g = idle_length();
            if (g > 0) begin
                g--; v = 1'b0;
            end else if (pending_items.size() > 0 && !hold_input) begin
                v = 1'b1; d = pending_items[0];
            end else begin
                v = 1'b0;
            end
        end
        in_gap <= g;
        s_tvalid <= v;
        s_tdata <= d;
    end

    // stall the result channel at random
    always @(negedge aclk) begin
        int g;
        g = out_gap;
        if (out_taken) g = idle_length();
        if (g > 0) begin
            g--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        out_gap <= g;
    end

    task automatic write_reg(logic idx, longint val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val[FB-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MODULUS) field_mod = val & 16'hffff;
        else field_a = val & 16'hffff;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_points.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic add_item(longint bx, longint by, longint k);
        base_item_t it;
        it.bx = bx[FB-1:0]; it.by = by[FB-1:0]; it.scalar = k[SB-1:0];
        pending_items.push_back(it);
    endtask

    task automatic add_random(int n);
        longint m, bx, by, k;
        for (int i = 0; i < n; i++) begin
            m = (field_mod < 2) ? 65536 : field_mod;
            if ($urandom_range(0, 9) < 8) begin
                bx = $urandom_range(0, m - 1); by = $urandom_range(0, m - 1);
            end else begin
                bx = $urandom_range(0, 65535); by = $urandom_range(0, 65535);
            end
            case ($urandom_range(0, 19))
                0: k = 0;
                1: k = 1;
                2: k = $urandom_range(2, 7);
                default: k = $urandom_range(0, 65535);
            endcase
            add_item(bx, by, k);
        end
    endtask

    initial begin
        longint mods[6] = '{97, 3, 15, 65521, 251, 65535};
        longint as[6]   = '{0, 2, 65534, 7, 65535, 1};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed items at reset values
        add_item(0, 0, 0);
        add_item(5, 1, 1);
        add_item(65535, 65535, 1);
        add_item(65534, 65534, 65535);
        add_item(3, 0, 2);
        add_item(3, 0, 3);
        add_item(2, 7, 2);
        add_item(0, 0, 65535);
        add_item(167, 167 + 5, 1);
        add_item(10, 20, 16'h8000);
        add_item(10, 20, 16'h5555);
        add_item(33, 12, 16'haaaa);
        drain();

        // no field at modulus zero or one
        write_reg(CFG_MODULUS, 0);
        write_reg(CFG_CURVE_A, 5);
        add_item(1, 2, 3);
        add_item(0, 0, 1);
        drain();
        write_reg(CFG_MODULUS, 1);
        add_item(1, 2, 3);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_MODULUS, mods[p]);
            write_reg(CFG_CURVE_A, as[p]);
            no_idle = (p == 2);
            add_random(42);
            if (p == 3) begin
                while (pending_items.size() > 30) @(posedge aclk);
                hold_input = 1'b1;
                while (expected_points.size() > 0) @(posedge aclk);
                hold_input = 1'b0;
            end
            drain();
        end
        write_reg(CFG_MODULUS, MODULUS_RESET);
        write_reg(CFG_CURVE_A, CURVE_A_RESET);
        add_random(20);

        while (pending_items.size() > 0 || expected_points.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
